[hw/rtl/drld_pkg.sv]
`timescale 1ns / 1ps
// Package with the shared types and constants of the data-run list decoder.
package drld_pkg;

	// Largest length or offset field, in bytes, that a header may announce.
	localparam logic [3:0] MAX_FIELD_BYTES = 4'd4;

	localparam int ACC_W     = 32;
	localparam int CLUSTER_W = 64;

	// Result kinds.
	localparam logic [1:0] KIND_RUN = 2'd0;
	localparam logic [1:0] KIND_END = 2'd1;
	localparam logic [1:0] KIND_ERR = 2'd2;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HEADER,
		PH_LENGTH,
		PH_OFFSET
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       list_start;
	} item_t;

	typedef struct packed {
		logic [1:0]           result_kind;
		logic [CLUSTER_W-1:0] run_first;
		logic [CLUSTER_W-1:0] run_end;
		logic [CLUSTER_W-1:0] lowest_cluster;
		logic [CLUSTER_W-1:0] highest_cluster;
	} result_t;

	// What the parser hands to the arithmetic stages for one result.
	typedef struct packed {
		logic [1:0]           kind;
		logic [CLUSTER_W-1:0] first;
		logic [ACC_W-1:0]     len;
	} run_s1_t;

endpackage

[hw/rtl/drld_parser.sv]
`timescale 1ns / 1ps
// Byte-level run list parser: header decode, field collection and running start cluster.
module drld_parser (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     accept,
	input  drld_pkg::item_t          item,
	input  logic                     s1_load,
	output logic                     valid_s1,
	output drld_pkg::run_s1_t        run_s1
);

	drld_pkg::phase_t phase_q, phase_n, phase_cur;
	logic [2:0]  bytes_left_q, bytes_left_n;
	logic [2:0]  length_size_q, length_size_n;
	logic [2:0]  offset_size_q, offset_size_n;
	logic [drld_pkg::ACC_W-1:0]     length_acc_q, length_acc_n;
	logic [drld_pkg::ACC_W-1:0]     offset_acc_q, offset_acc_n;
	logic [drld_pkg::CLUSTER_W-1:0] base_q, base_n, base_cur;
	logic [drld_pkg::CLUSTER_W-1:0] off_ext;

	logic [3:0] ls, os;
	logic       hdr_end, hdr_err;
	logic [2:0] left_dec;
	logic       field_done;
	logic [1:0] lane;

	logic                    res_v;
	drld_pkg::run_s1_t       res;

	assign ls        = item.data_byte[3:0];
	assign os        = item.data_byte[7:4];
	assign hdr_end   = (ls == 4'd0) || (os == 4'd0);
	assign hdr_err   = (ls > drld_pkg::MAX_FIELD_BYTES) || (os > drld_pkg::MAX_FIELD_BYTES);
	assign phase_cur = item.list_start ? drld_pkg::PH_HEADER : phase_q;
	assign base_cur  = item.list_start ? '0 : base_q;
	assign left_dec  = bytes_left_q - 3'd1;
	assign field_done = (left_dec == 3'd0);

	// Next phase.
	always_comb begin
		phase_n = phase_cur;
		case (phase_cur)
			drld_pkg::PH_HEADER: begin
				if (hdr_end || hdr_err) begin
					phase_n = drld_pkg::PH_IDLE;
				end else begin
					phase_n = drld_pkg::PH_LENGTH;
				end
			end
			drld_pkg::PH_LENGTH: begin
				if (field_done) begin
					phase_n = drld_pkg::PH_OFFSET;
				end
			end
			drld_pkg::PH_OFFSET: begin
				if (field_done) begin
					phase_n = drld_pkg::PH_HEADER;
				end
			end
			default: begin
				phase_n = phase_cur;
			end
		endcase
	end

	// Datapath and result.
	always_comb begin
		bytes_left_n  = bytes_left_q;
		length_size_n = length_size_q;
		offset_size_n = offset_size_q;
		length_acc_n  = length_acc_q;
		offset_acc_n  = offset_acc_q;
		base_n        = base_cur;
		off_ext       = '0;
		lane          = 2'd0;
		res_v         = 1'b0;
		res.kind      = drld_pkg::KIND_RUN;
		res.first     = '0;
		res.len       = '0;
		case (phase_cur)
			drld_pkg::PH_HEADER: begin
				length_acc_n = '0;
				offset_acc_n = '0;
				if (hdr_end) begin
					res_v    = 1'b1;
					res.kind = drld_pkg::KIND_END;
				end else if (hdr_err) begin
					res_v    = 1'b1;
					res.kind = drld_pkg::KIND_ERR;
				end else begin
					length_size_n = ls[2:0];
					offset_size_n = os[2:0];
					bytes_left_n  = ls[2:0];
				end
			end
			drld_pkg::PH_LENGTH: begin
				lane = 2'(length_size_q - bytes_left_q);
				length_acc_n[{lane, 3'b000} +: 8] =
					length_acc_q[{lane, 3'b000} +: 8] | item.data_byte;
				bytes_left_n = field_done ? offset_size_q : left_dec;
			end
			drld_pkg::PH_OFFSET: begin
				lane = 2'(offset_size_q - bytes_left_q);
				offset_acc_n[{lane, 3'b000} +: 8] =
					offset_acc_q[{lane, 3'b000} +: 8] | item.data_byte;
				bytes_left_n = left_dec;
				if (field_done) begin
					// Sign-extend the offset from its announced byte count.
					case (offset_size_q)
						3'd1: off_ext = {{56{offset_acc_n[7]}}, offset_acc_n[7:0]};
						3'd2: off_ext = {{48{offset_acc_n[15]}}, offset_acc_n[15:0]};
						3'd3: off_ext = {{40{offset_acc_n[23]}}, offset_acc_n[23:0]};
						3'd4: off_ext = {{32{offset_acc_n[31]}}, offset_acc_n[31:0]};
						default: off_ext = {32'd0, offset_acc_n};
					endcase
					base_n       = base_cur + off_ext;
					bytes_left_n = 3'd0;
					res_v        = 1'b1;
					res.kind     = drld_pkg::KIND_RUN;
					res.first    = base_n;
					res.len      = length_acc_q;
				end
			end
			default: begin
				bytes_left_n = bytes_left_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= drld_pkg::PH_IDLE;
			bytes_left_q  <= '0;
			length_size_q <= '0;
			offset_size_q <= '0;
			length_acc_q  <= '0;
			offset_acc_q  <= '0;
			base_q        <= '0;
		end else if (accept) begin
			phase_q       <= phase_n;
			bytes_left_q  <= bytes_left_n;
			length_size_q <= length_size_n;
			offset_size_q <= offset_size_n;
			length_acc_q  <= length_acc_n;
			offset_acc_q  <= offset_acc_n;
			base_q        <= base_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_load) begin
			valid_s1 <= accept && res_v;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load && accept && res_v) begin
			run_s1 <= res;
		end
	end

endmodule

[hw/rtl/data_run_list_decoder.sv]
`timescale 1ns / 1ps
// Top level of the data-run list decoder.
//
// The block takes a run list one byte per transaction on the item channel
// (item_valid, item_stall, item). Setting list_start marks the first header
// byte of a new list and clears the running start cluster. Bytes that arrive
// with no list open are dropped without a result.
// Each finished run, each end-of-list header and each oversized header gives
// one transaction on the result channel (result_valid, result_stall, result),
// which also carries the lowest start and highest end cluster seen since reset.
// One byte is taken every cycle while item_stall is low. The byte passes three
// registers: the parser register, a stage that forms the run end, and the
// output register that updates the extremes and drives result_valid.
// When the receiver stalls, the output register holds its transaction and
// stall spreads back through the stages only as far as they are full, so
// bubbles are squeezed out before the item channel is stalled.
// Reset empties all stages, closes any open list and sets the lowest cluster
// to all ones and the highest cluster to zero.
module data_run_list_decoder (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  drld_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output drld_pkg::result_t result
);

	logic accept;
	logic out_free, s2_free, s1_free;

	logic              valid_s1;
	drld_pkg::run_s1_t run_s1;

	logic                           valid_s2;
	logic [1:0]                     kind_s2;
	logic [drld_pkg::CLUSTER_W-1:0] first_s2;
	logic [drld_pkg::CLUSTER_W-1:0] end_s2;

	logic [drld_pkg::CLUSTER_W-1:0] lowest_q, highest_q;
	logic [drld_pkg::CLUSTER_W-1:0] lowest_n, highest_n;
	logic                           is_run;

	// A stage takes new data when it is empty or its contents move on.
	assign out_free   = !result_valid || !result_stall;
	assign s2_free    = !valid_s2 || out_free;
	assign s1_free    = !valid_s1 || s2_free;
	assign item_stall = !s1_free;
	assign accept     = item_valid && s1_free;

	drld_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (item),
		.s1_load  (s1_free),
		.valid_s1 (valid_s1),
		.run_s1   (run_s1)
	);

	// Stage two: run end is the start plus the length.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && valid_s1) begin
			kind_s2  <= run_s1.kind;
			first_s2 <= run_s1.first;
			end_s2   <= run_s1.first + {32'd0, run_s1.len};
		end
	end

	// Output stage: fold a run into the global extremes. Non-run results
	// report the extremes as they stand after every earlier run.
	assign is_run    = (kind_s2 == drld_pkg::KIND_RUN);
	assign lowest_n  = (is_run && (first_s2 < lowest_q)) ? first_s2 : lowest_q;
	assign highest_n = (is_run && (end_s2 > highest_q)) ? end_s2 : highest_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
			lowest_q     <= '1;
			highest_q    <= '0;
		end else if (out_free) begin
			result_valid <= valid_s2;
			if (valid_s2) begin
				lowest_q  <= lowest_n;
				highest_q <= highest_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s2) begin
			result.result_kind     <= kind_s2;
			result.run_first       <= first_s2;
			result.run_end         <= end_s2;
			result.lowest_cluster  <= lowest_n;
			result.highest_cluster <= highest_n;
		end
	end

endmodule
